[src/obv_adl_accumulator_macros.svh]
// Assertion macros used by the accumulator RTL.
`ifndef OBV_ADL_ACCUMULATOR_MACROS_SVH
`define OBV_ADL_ACCUMULATOR_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define OBVADL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define OBVADL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/obvadl_pkg.sv]
// Types and constants of the OBV / accumulation-distribution accumulator.
`default_nettype none

package obvadl_pkg;

   // Field widths
   localparam int IN_W      = 32;
   localparam int OBV_W     = 48;
   localparam int ADL_W     = 53;
   localparam int OBV_CHG_W = 49;
   localparam int ADL_CHG_W = 54;

   // Stream packing
   localparam int REQ_DATA_W  = 4 * IN_W;
   localparam int OBV_LSB     = 0;
   localparam int ADL_LSB     = OBV_LSB + OBV_W;
   localparam int OBV_CHG_LSB = ADL_LSB + ADL_W;
   localparam int ADL_CHG_LSB = OBV_CHG_LSB + OBV_CHG_W;
   localparam int RSP_USED_W  = ADL_CHG_LSB + ADL_CHG_W;
   localparam int RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_USED_W;
   localparam int RSP_USER_W  = 1;

   // Datapath widths: numerator 2*close-low-high, divisor high-low
   localparam int NUM_W     = IN_W + 3;
   localparam int DIF_W     = IN_W + 1;
   localparam int MAG_W     = IN_W + 1;
   localparam int DEN_W     = IN_W;
   localparam int PROD_W    = MAG_W + IN_W;
   localparam int FRAC_W    = 16;
   localparam int QUO_W     = 54;
   localparam int CHK_LSB   = QUO_W - FRAC_W;
   localparam int OBV_SUM_W = OBV_W + 2;
   localparam int TERM_W    = QUO_W + 1;
   localparam int ADL_SUM_W = TERM_W + 1;

   // Sequencer step counts
   localparam int MUL_STEPS = IN_W;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = 6;

   localparam int HISTORY_DEPTH_DEF = 11;

   // Saturation limits
   localparam logic [OBV_W-1:0] OBV_MAX = {1'b0, {(OBV_W-1){1'b1}}};
   localparam logic [OBV_W-1:0] OBV_MIN = {1'b1, {(OBV_W-1){1'b0}}};
   localparam logic [ADL_W-1:0] ADL_MAX = {1'b0, {(ADL_W-1){1'b1}}};
   localparam logic [ADL_W-1:0] ADL_MIN = {1'b1, {(ADL_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_ADD,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

[src/obv_adl_accumulator.sv]
// On-balance volume and accumulation/distribution line over a stream of price bars.
//
// Usage:
//   req_* carries one price bar per transaction (high, low, close, volume);
//   rsp_* returns exactly one result per bar: both running totals, their
//   change over the last HISTORY_DEPTH-1 bars, and a flag in rsp_tuser
//   that is set once HISTORY_DEPTH bars have been seen.
// Timing:
//   A bar is accepted only in the idle state, so a new bar is taken only
//   once the last one has moved its result into the output register. A
//   bar passes through the shift-add multiplier (32 steps, one volume bit
//   per cycle) and the restoring divider (54 steps, one quotient bit per
//   cycle). A bar with high equal to low, or whose term saturates, skips
//   the divider.
// Reset:
//   Synchronous, active high; clears totals, history count and the
//   previous close. No clearing pass is needed.
// Backpressure:
//   The result sits in an output register, so the next bar is accepted
//   and computed while it waits; a finished bar then holds until
//   rsp_tready frees the output register.
`default_nettype none

`include "obv_adl_accumulator_macros.svh"

module obv_adl_accumulator #(
   parameter int HISTORY_DEPTH = obvadl_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // bar transactions
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [31:0] bar_high, [63:32] bar_low, [95:64] bar_close, [127:96] bar_volume
   input  wire logic [obvadl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // result transactions
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [47:0] obv_total, [100:48] adl_total, [149:101] obv_change,
   // [203:150] adl_change, [207:204] zero fill
   output logic [obvadl_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // [0] change_valid
   output logic [obvadl_pkg::RSP_USER_W-1:0]        rsp_tuser
);

   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int TAPS   = HISTORY_DEPTH - 1;

   // Bar fields
   logic [obvadl_pkg::IN_W-1:0] bar_high;
   logic [obvadl_pkg::IN_W-1:0] bar_low;
   logic [obvadl_pkg::IN_W-1:0] bar_close;
   logic [obvadl_pkg::IN_W-1:0] bar_volume;

   // Control state
   obvadl_pkg::state_type state_ff, state_in;
   logic [obvadl_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                         have_ff, have_in;
   logic [obvadl_pkg::IN_W-1:0]  last_close_ff, last_close_in;
   logic [obvadl_pkg::OBV_W-1:0] obv_acc_ff, obv_acc_in;
   logic [obvadl_pkg::ADL_W-1:0] adl_acc_ff, adl_acc_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;

   // Working registers
   logic [obvadl_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [obvadl_pkg::DIF_W-1:0]  dif_ff, dif_in;
   logic [obvadl_pkg::IN_W-1:0]   vol_ff, vol_in;
   logic                          up_ff, up_in;
   logic                          dn_ff, dn_in;
   logic [obvadl_pkg::MAG_W-1:0]  a_ff, a_in;
   logic [obvadl_pkg::DEN_W-1:0]  den_ff, den_in;
   logic                          neg_ff, neg_in;
   logic                          zero_ff, zero_in;
   logic [obvadl_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [obvadl_pkg::DEN_W-1:0]  rem_ff, rem_in;
   logic [obvadl_pkg::QUO_W-1:0]  dvd_ff, dvd_in;
   logic [obvadl_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [obvadl_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   // History lines: tap k holds the total of k+1 bars earlier
   logic [obvadl_pkg::OBV_W-1:0] hobv_ff [TAPS];
   logic [obvadl_pkg::ADL_W-1:0] hadl_ff [TAPS];

   // Sequencer outputs
   logic slot_free;
   logic load_rsp;
   logic accept;
   logic ovf;

   // Arithmetic nets
   logic [obvadl_pkg::NUM_W-1:0]     num_neg;
   logic [obvadl_pkg::DIF_W-1:0]     dif_neg;
   logic [obvadl_pkg::MAG_W-1:0]     addend;
   logic [obvadl_pkg::MAG_W:0]       psum;
   logic [obvadl_pkg::DEN_W:0]       trial;
   logic [obvadl_pkg::DEN_W:0]       trial_sub;
   logic                             trial_ge;
   logic [obvadl_pkg::OBV_SUM_W-1:0] obv_add;
   logic [obvadl_pkg::OBV_SUM_W-1:0] obv_sum;
   logic [obvadl_pkg::TERM_W-1:0]    mag_ext;
   logic [obvadl_pkg::TERM_W-1:0]    term;
   logic [obvadl_pkg::ADL_SUM_W-1:0] adl_sum;
   logic                             chg_valid;
   logic [obvadl_pkg::OBV_CHG_W-1:0] obv_chg;
   logic [obvadl_pkg::ADL_CHG_W-1:0] adl_chg;

   // Unpack the bar
   assign bar_high   = req_tdata[obvadl_pkg::IN_W-1:0];
   assign bar_low    = req_tdata[2*obvadl_pkg::IN_W-1:obvadl_pkg::IN_W];
   assign bar_close  = req_tdata[3*obvadl_pkg::IN_W-1:2*obvadl_pkg::IN_W];
   assign bar_volume = req_tdata[4*obvadl_pkg::IN_W-1:3*obvadl_pkg::IN_W];

   assign slot_free = !rsp_tvalid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;

   // Term exceeds the quotient range: saturate instead of dividing
   assign ovf = obvadl_pkg::DEN_W'(prod_ff[obvadl_pkg::PROD_W-1:obvadl_pkg::CHK_LSB]) >= den_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         obvadl_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = obvadl_pkg::ST_PREP;
         end
         obvadl_pkg::ST_PREP: begin
            state_in = obvadl_pkg::ST_MUL;
         end
         obvadl_pkg::ST_MUL: begin
            if (cnt_ff == obvadl_pkg::CNT_W'(obvadl_pkg::MUL_STEPS - 1))
               state_in = obvadl_pkg::ST_CHECK;
         end
         obvadl_pkg::ST_CHECK: begin
            if (zero_ff || ovf) state_in = obvadl_pkg::ST_ADD;
            else                state_in = obvadl_pkg::ST_DIV;
         end
         obvadl_pkg::ST_DIV: begin
            if (cnt_ff == obvadl_pkg::CNT_W'(obvadl_pkg::DIV_STEPS - 1))
               state_in = obvadl_pkg::ST_ADD;
         end
         obvadl_pkg::ST_ADD: begin
            state_in = obvadl_pkg::ST_FIN;
         end
         obvadl_pkg::ST_FIN: begin
            if (slot_free) state_in = obvadl_pkg::ST_IDLE;
         end
         default: begin
            state_in = obvadl_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         obvadl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         obvadl_pkg::ST_FIN: begin
            load_rsp = slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Datapath
   always_comb begin
      num_in        = num_ff;
      dif_in        = dif_ff;
      vol_in        = vol_ff;
      up_in         = up_ff;
      dn_in         = dn_ff;
      a_in          = a_ff;
      den_in        = den_ff;
      neg_in        = neg_ff;
      zero_in       = zero_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      cnt_in        = cnt_ff;
      have_in       = have_ff;
      last_close_in = last_close_ff;
      obv_acc_in    = obv_acc_ff;
      adl_acc_in    = adl_acc_ff;
      fill_in       = fill_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      // Absolute values for the divider operands
      num_neg = -num_ff;
      dif_neg = -dif_ff;

      // One shift-add step: add the operand when the low volume bit is set
      addend = prod_ff[0] ? a_ff : '0;
      psum   = {1'b0, prod_ff[obvadl_pkg::PROD_W-1:obvadl_pkg::IN_W]} + {1'b0, addend};

      // One restoring division step
      trial     = {rem_ff, dvd_ff[obvadl_pkg::QUO_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      trial_ge  = trial >= {1'b0, den_ff};

      // Saturating OBV update
      obv_add = {{(obvadl_pkg::OBV_SUM_W - obvadl_pkg::IN_W){1'b0}}, vol_ff};
      obv_sum = {{2{obv_acc_ff[obvadl_pkg::OBV_W-1]}}, obv_acc_ff}
              + (up_ff ? obv_add : (dn_ff ? -obv_add : '0));

      // Saturating ADL update with the signed Q16 term
      mag_ext = {1'b0, dvd_ff};
      term    = neg_ff ? -mag_ext : mag_ext;
      adl_sum = {{(obvadl_pkg::ADL_SUM_W - obvadl_pkg::ADL_W){adl_acc_ff[obvadl_pkg::ADL_W-1]}},
                 adl_acc_ff}
              + {term[obvadl_pkg::TERM_W-1], term};

      // Change over the history window
      chg_valid = fill_ff >= FILL_W'(HISTORY_DEPTH - 1);
      obv_chg   = {obv_acc_ff[obvadl_pkg::OBV_W-1], obv_acc_ff}
                - {hobv_ff[TAPS-1][obvadl_pkg::OBV_W-1], hobv_ff[TAPS-1]};
      adl_chg   = {adl_acc_ff[obvadl_pkg::ADL_W-1], adl_acc_ff}
                - {hadl_ff[TAPS-1][obvadl_pkg::ADL_W-1], hadl_ff[TAPS-1]};

      case (state_ff)
         obvadl_pkg::ST_IDLE: begin
            // Capture the bar and the close direction
            if (accept) begin
               num_in        = {2'b00, bar_close, 1'b0} - {3'b000, bar_low} - {3'b000, bar_high};
               dif_in        = {1'b0, bar_high} - {1'b0, bar_low};
               vol_in        = bar_volume;
               up_in         = have_ff && (bar_close > last_close_ff);
               dn_in         = have_ff && (bar_close < last_close_ff);
               last_close_in = bar_close;
               have_in       = 1'b1;
            end
         end
         obvadl_pkg::ST_PREP: begin
            // Split signs from magnitudes, load the multiplier
            a_in    = num_ff[obvadl_pkg::NUM_W-1] ? num_neg[obvadl_pkg::MAG_W-1:0]
                                                  : num_ff[obvadl_pkg::MAG_W-1:0];
            den_in  = dif_ff[obvadl_pkg::DIF_W-1] ? dif_neg[obvadl_pkg::DEN_W-1:0]
                                                  : dif_ff[obvadl_pkg::DEN_W-1:0];
            neg_in  = num_ff[obvadl_pkg::NUM_W-1] ^ dif_ff[obvadl_pkg::DIF_W-1];
            zero_in = (dif_ff == '0);
            prod_in = {{obvadl_pkg::MAG_W{1'b0}}, vol_ff};
            cnt_in  = '0;
         end
         obvadl_pkg::ST_MUL: begin
            // Advance the product one volume bit
            prod_in = {psum, prod_ff[obvadl_pkg::IN_W-1:1]};
            if (cnt_ff == obvadl_pkg::CNT_W'(obvadl_pkg::MUL_STEPS - 1)) cnt_in = '0;
            else                                                         cnt_in = cnt_ff + 1'b1;
         end
         obvadl_pkg::ST_CHECK: begin
            // Seed the divider with the top of product * 2^16
            rem_in = obvadl_pkg::DEN_W'(prod_ff[obvadl_pkg::PROD_W-1:obvadl_pkg::CHK_LSB]);
            if (zero_ff)  dvd_in = '0;
            else if (ovf) dvd_in = '1;
            else          dvd_in = {prod_ff[obvadl_pkg::CHK_LSB-1:0], {obvadl_pkg::FRAC_W{1'b0}}};
            cnt_in = '0;
         end
         obvadl_pkg::ST_DIV: begin
            // Shift in one quotient bit
            rem_in = trial_ge ? trial_sub[obvadl_pkg::DEN_W-1:0] : trial[obvadl_pkg::DEN_W-1:0];
            dvd_in = {dvd_ff[obvadl_pkg::QUO_W-2:0], trial_ge};
            if (cnt_ff == obvadl_pkg::CNT_W'(obvadl_pkg::DIV_STEPS - 1)) cnt_in = '0;
            else                                                         cnt_in = cnt_ff + 1'b1;
         end
         obvadl_pkg::ST_ADD: begin
            // Add both terms and clamp to the field ranges
            if ((&obv_sum[obvadl_pkg::OBV_SUM_W-1:obvadl_pkg::OBV_W-1])
                || !(|obv_sum[obvadl_pkg::OBV_SUM_W-1:obvadl_pkg::OBV_W-1]))
               obv_acc_in = obv_sum[obvadl_pkg::OBV_W-1:0];
            else if (obv_sum[obvadl_pkg::OBV_SUM_W-1])
               obv_acc_in = obvadl_pkg::OBV_MIN;
            else
               obv_acc_in = obvadl_pkg::OBV_MAX;
            if ((&adl_sum[obvadl_pkg::ADL_SUM_W-1:obvadl_pkg::ADL_W-1])
                || !(|adl_sum[obvadl_pkg::ADL_SUM_W-1:obvadl_pkg::ADL_W-1]))
               adl_acc_in = adl_sum[obvadl_pkg::ADL_W-1:0];
            else if (adl_sum[obvadl_pkg::ADL_SUM_W-1])
               adl_acc_in = obvadl_pkg::ADL_MIN;
            else
               adl_acc_in = obvadl_pkg::ADL_MAX;
         end
         obvadl_pkg::ST_FIN: begin
            // Load the result and count the bar into the history
            if (load_rsp) begin
               rsp_data_in = {{obvadl_pkg::RSP_PAD_W{1'b0}},
                              chg_valid ? adl_chg : {obvadl_pkg::ADL_CHG_W{1'b0}},
                              chg_valid ? obv_chg : {obvadl_pkg::OBV_CHG_W{1'b0}},
                              adl_acc_ff,
                              obv_acc_ff};
               rsp_user_in = chg_valid;
               if (fill_ff != FILL_W'(HISTORY_DEPTH)) fill_in = fill_ff + 1'b1;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase

      // Output register: hold until taken
      if (load_rsp)        rsp_tvalid_in = 1'b1;
      else if (rsp_tready) rsp_tvalid_in = 1'b0;
      else                 rsp_tvalid_in = rsp_tvalid_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= obvadl_pkg::ST_IDLE;
         cnt_ff        <= '0;
         have_ff       <= 1'b0;
         last_close_ff <= '0;
         obv_acc_ff    <= '0;
         adl_acc_ff    <= '0;
         fill_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         have_ff       <= have_in;
         last_close_ff <= last_close_in;
         obv_acc_ff    <= obv_acc_in;
         adl_acc_ff    <= adl_acc_in;
         fill_ff       <= fill_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      dif_ff      <= dif_in;
      vol_ff      <= vol_in;
      up_ff       <= up_in;
      dn_ff       <= dn_in;
      a_ff        <= a_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Shift the history lines once per finished bar
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         hobv_ff[0] <= obv_acc_ff;
         hadl_ff[0] <= adl_acc_ff;
         for (int i = 1; i < TAPS; i++) begin
            hobv_ff[i] <= hobv_ff[i-1];
            hadl_ff[i] <= hadl_ff[i-1];
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Checks
   `OBVADL_ASSERT_SAME(a_div_rem, clock, reset,
      state_ff == obvadl_pkg::ST_DIV, rem_ff < den_ff,
      "divider remainder not below divisor")
   `OBVADL_ASSERT_NEXT(a_accept_seq, clock, reset,
      req_tvalid && req_tready, state_ff == obvadl_pkg::ST_PREP,
      "accepted bar did not start the sequence")
   `OBVADL_ASSERT_SAME(a_chg_zero, clock, reset,
      rsp_tvalid_ff && !rsp_user_ff[0],
      rsp_data_ff[obvadl_pkg::RSP_USED_W-1:obvadl_pkg::OBV_CHG_LSB] == '0,
      "change fields set before history is full")
   `OBVADL_ASSERT_SAME(a_chg_fill, clock, reset,
      rsp_tvalid_ff && rsp_user_ff[0], fill_ff == FILL_W'(HISTORY_DEPTH),
      "change flagged valid without full history")

endmodule

`default_nettype wire

[sim/obv_adl_accumulator_tb.sv]
// Self-checking stream testbench for the OBV / accumulation-distribution accumulator.
`timescale 1ns / 100ps

module obv_adl_accumulator_tb;

   localparam int       IN_W        = obvadl_pkg::IN_W;
   localparam int       OBV_W       = obvadl_pkg::OBV_W;
   localparam int       ADL_W       = obvadl_pkg::ADL_W;
   localparam int       OBV_CHG_W   = obvadl_pkg::OBV_CHG_W;
   localparam int       ADL_CHG_W   = obvadl_pkg::ADL_CHG_W;
   localparam int       REQ_DATA_W  = obvadl_pkg::REQ_DATA_W;
   localparam int       RSP_DATA_W  = obvadl_pkg::RSP_DATA_W;
   localparam int       RSP_USER_W  = obvadl_pkg::RSP_USER_W;
   localparam int       OBV_LSB     = obvadl_pkg::OBV_LSB;
   localparam int       ADL_LSB     = obvadl_pkg::ADL_LSB;
   localparam int       OBV_CHG_LSB = obvadl_pkg::OBV_CHG_LSB;
   localparam int       ADL_CHG_LSB = obvadl_pkg::ADL_CHG_LSB;

   localparam int       HDEPTH     = obvadl_pkg::HISTORY_DEPTH_DEF;
   localparam longint   OBV_CEIL   = 64'sd140737488355327;
   localparam longint   ADL_CEIL   = 64'sd4503599627370495;
   localparam logic [127:0] TERM_CAP = 128'd1 << 55;
   localparam int       LONG_STALL = 500;
   localparam int       TAIL_CYCLES = 120;
   localparam int       PRINT_LIMIT = 40;

   typedef struct {
      logic [IN_W-1:0] bar_high;
      logic [IN_W-1:0] bar_low;
      logic [IN_W-1:0] bar_close;
      logic [IN_W-1:0] bar_volume;
   } bar_type;

   typedef struct {
      logic [OBV_W-1:0]     obv_total;
      logic [ADL_W-1:0]     adl_total;
      logic [OBV_CHG_W-1:0] obv_change;
      logic [ADL_CHG_W-1:0] adl_change;
      logic                 change_valid;
   } totals_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // pending bars and totals still owed by the block
   bar_type    bar_queue[$];
   totals_type totals_expected[$];

   // indicator state mirrored from the block
   logic [IN_W-1:0] seen_close = '0;
   bit              have_prev  = 1'b0;
   longint          obv_run    = 0;
   longint          adl_run    = 0;
   longint          obv_ring[HDEPTH] = '{default: 0};
   longint          adl_ring[HDEPTH] = '{default: 0};
   int              ring_fill  = 0;
   int              ring_wr    = 0;

   // traffic control
   bit              idle_on     = 1'b1;
   bit              stall_armed = 1'b0;
   bit              stall_done  = 1'b0;
   bit              req_fire    = 1'b0;
   int              send_gap    = 0;
   int              stall_left  = 0;
   logic [IN_W-1:0] gen_close   = '0;

   int              mismatches      = 0;
   int              bars_sent       = 0;
   int              results_checked = 0;
   int              saturated_sums  = 0;
   int              valid_slopes    = 0;

   obv_adl_accumulator #(.HISTORY_DEPTH(HDEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("timeout: %0d bars sent, %0d results checked", bars_sent, results_checked);
      $display("status: fail");
      $finish;
   end

   function automatic longint saturate(input longint v, input longint ceil_v);
      if (v > ceil_v) begin
         saturated_sums++;
         return ceil_v;
      end
      if (v < -ceil_v - 1) begin
         saturated_sums++;
         return -ceil_v - 1;
      end
      return v;
   endfunction

   // Advance both running totals by one bar and return the result the block owes.
   function automatic totals_type advance_indicators(input logic [REQ_DATA_W-1:0] word);
      longint       hi_v, lo_v, cl_v, vol, num, den, term, obv_d, adl_d;
      logic [127:0] num_mag, den_mag, vol_w, quot;
      totals_type   r;
      hi_v  = longint'({32'd0, word[0*IN_W +: IN_W]});
      lo_v  = longint'({32'd0, word[1*IN_W +: IN_W]});
      cl_v  = longint'({32'd0, word[2*IN_W +: IN_W]});
      vol   = longint'({32'd0, word[3*IN_W +: IN_W]});
      vol_w = {96'd0, word[3*IN_W +: IN_W]};

      // on-balance volume follows the direction of the close
      if (have_prev) begin
         if (word[2*IN_W +: IN_W] > seen_close)
            obv_run = saturate(obv_run + vol, OBV_CEIL);
         else if (word[2*IN_W +: IN_W] < seen_close)
            obv_run = saturate(obv_run - vol, OBV_CEIL);
      end

      // money-flow term in Q16, truncated toward zero, magnitude capped
      term = 0;
      if (hi_v != lo_v) begin
         num     = 2 * cl_v - lo_v - hi_v;
         den     = hi_v - lo_v;
         num_mag = (num < 0) ? -num : num;
         den_mag = (den < 0) ? -den : den;
         quot    = (num_mag * vol_w * 128'd65536) / den_mag;
         if (quot > TERM_CAP)
            quot = TERM_CAP;
         term = longint'(quot[63:0]);
         if ((num < 0) != (den < 0))
            term = -term;
      end
      adl_run = saturate(adl_run + term, ADL_CEIL);

      seen_close = word[2*IN_W +: IN_W];
      have_prev  = 1'b1;

      // record history; the oldest entry of a full ring is the next slot
      obv_ring[ring_wr] = obv_run;
      adl_ring[ring_wr] = adl_run;
      ring_wr = (ring_wr + 1) % HDEPTH;
      if (ring_fill < HDEPTH)
         ring_fill++;
      r.change_valid = (ring_fill >= HDEPTH);
      obv_d = r.change_valid ? obv_run - obv_ring[ring_wr] : 0;
      adl_d = r.change_valid ? adl_run - adl_ring[ring_wr] : 0;

      r.obv_total  = obv_run[OBV_W-1:0];
      r.adl_total  = adl_run[ADL_W-1:0];
      r.obv_change = obv_d[OBV_CHG_W-1:0];
      r.adl_change = adl_d[ADL_CHG_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch at result %0d, %s: got %h, want %h",
                  results_checked, what, got, want);
   endtask

   task automatic push_bar(input logic [31:0] h, input logic [31:0] l,
                           input logic [31:0] c, input logic [31:0] v);
      bar_type b;
      b.bar_high   = h;
      b.bar_low    = l;
      b.bar_close  = c;
      b.bar_volume = v;
      gen_close    = c;
      bar_queue.insert(bar_queue.size(), b);
   endtask

   // Mostly well-formed bars with random ranges, plus flat, inverted, unchanged-close and raw noise.
   task automatic queue_random_bar();
      logic [31:0] h, l, c, v, span, swap;
      int          kind;
      kind = $urandom_range(0, 9);
      v    = $urandom >> $urandom_range(0, 31);
      l    = $urandom;
      span = $urandom >> $urandom_range(0, 31);
      h    = (l > ~span) ? 32'hFFFF_FFFF : l + span;
      c    = l + 32'(({1'b0, $urandom}) % ({1'b0, h - l} + 33'd1));
      if (kind == 6) begin
         h = l;
         c = $urandom;
      end else if (kind == 7) begin
         swap = h;
         h    = l;
         l    = swap;
      end else if (kind == 8) begin
         h = $urandom;
         l = $urandom;
         c = $urandom;
         v = $urandom;
      end else if (kind == 9) begin
         c = gen_close;
      end
      push_bar(h, l, c, v);
   endtask

   task automatic wait_drained();
      while (bar_queue.size() != 0 || req_tvalid || totals_expected.size() != 0)
         @(posedge clock);
   endtask

   // Offer bars; idle in bursts only while no transaction is pending.
   always @(negedge clock) begin : bar_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (send_gap != 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 1) == 0) begin
            send_gap   <= $urandom_range(0, 10);
            req_tvalid <= 1'b0;
         end else if (bar_queue.size() != 0) begin
            req_tdata  <= {bar_queue[0].bar_volume, bar_queue[0].bar_close,
                           bar_queue[0].bar_low, bar_queue[0].bar_high};
            req_tvalid <= 1'b1;
            bar_queue.delete(0);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Drive the result ready with random stall bursts and one long hold-off.
   always @(negedge clock) begin : result_ready_driver
      if (stall_armed && !stall_done) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Count out the long hold-off once it is armed.
   initial begin
      wait (stall_armed);
      repeat (LONG_STALL) @(posedge clock);
      stall_done = 1'b1;
   end

   // Predict on each accepted bar; check each accepted result against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      totals_type want;
      totals_type got;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            totals_expected.insert(totals_expected.size(), advance_indicators(req_tdata));
            bars_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.obv_total    = rsp_tdata[OBV_LSB +: OBV_W];
            got.adl_total    = rsp_tdata[ADL_LSB +: ADL_W];
            got.obv_change   = rsp_tdata[OBV_CHG_LSB +: OBV_CHG_W];
            got.adl_change   = rsp_tdata[ADL_CHG_LSB +: ADL_CHG_W];
            got.change_valid = rsp_tuser[0];
            if (totals_expected.size() == 0) begin
               report_mismatch("result with nothing expected", 64'(got.obv_total), 64'd0);
            end else begin
               want = totals_expected[0];
               totals_expected.delete(0);
               if (got.obv_total !== want.obv_total)
                  report_mismatch("obv_total", 64'(got.obv_total), 64'(want.obv_total));
               if (got.adl_total !== want.adl_total)
                  report_mismatch("adl_total", 64'(got.adl_total), 64'(want.adl_total));
               if (got.obv_change !== want.obv_change)
                  report_mismatch("obv_change", 64'(got.obv_change), 64'(want.obv_change));
               if (got.adl_change !== want.adl_change)
                  report_mismatch("adl_change", 64'(got.adl_change), 64'(want.adl_change));
               if (got.change_valid !== want.change_valid)
                  report_mismatch("change_valid", 64'(got.change_valid),
                                  64'(want.change_valid));
               if (want.change_valid)
                  valid_slopes++;
            end
            results_checked++;
         end
      end
   end

   initial begin : stimulus
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed bars: range extremes, inverted and flat bars, capped terms
      push_bar(32'h0, 32'h0, 32'h0, 32'h0);                      // first bar, flat
      push_bar(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // close rose, full range
      push_bar(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);      // high below low, close fell
      push_bar(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678); // unchanged close
      push_bar(32'h1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);      // capped term, ADL top
      push_bar(32'h1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_bar(32'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);      // capped term, ADL bottom
      push_bar(32'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_bar(32'd3, 32'd0, 32'd1, 32'd1);                      // truncation, negative
      push_bar(32'd3, 32'd0, 32'd2, 32'd1);                      // truncation, positive
      push_bar(32'd3, 32'd0, 32'd0, 32'd0);                      // zero volume
      push_bar(32'd7, 32'd3, 32'd5, 32'd9);                      // zero numerator
      push_bar(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0, 32'hFFFF_FFFF);
      push_bar(32'd5, 32'd10, 32'd7, 32'd100);
      push_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'hAAAA_AAAA);
      push_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h5555_5555);
      push_bar(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      push_bar(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1);
      push_bar(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF);
      push_bar(32'd10, 32'd0, 32'd10, 32'hFFFF_FFFF);
      push_bar(32'd10, 32'd0, 32'd10, 32'hFFFF_FFFF);
      wait_drained();

      // hold the result side off while bars keep coming, so the input stalls
      stall_armed = 1'b1;
      repeat (20) queue_random_bar();
      wait_drained();

      // random bars with idling on both sides
      repeat (560) queue_random_bar();
      wait_drained();

      // no idling from here on
      idle_on = 1'b0;
      repeat (100) queue_random_bar();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d bars and %0d checked results, %0d with valid slopes;",
               bars_sent, results_checked, valid_slopes);
      $display("%0d saturating sums, %0d mismatches", saturated_sums, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
